### design/lpcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcf_pkg
// Shared types, register codes and check-field functions for the framer.
// ----------------------------------------------------------------------------
package lpcf_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_CONSTANT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ADDRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_ADDRESS   = 2'd2;

    localparam logic [15:0] FRAME_CONSTANT_RST = 16'h54FD;
    localparam logic [15:0] SOURCE_ADDRESS_RST = 16'h6400;
    localparam logic [15:0] DEST_ADDRESS_RST   = 16'h6401;

    localparam logic MODE_HEADER  = 1'b0;
    localparam logic MODE_PAYLOAD = 1'b1;

    typedef struct packed {
        logic [15:0] frame_constant;
        logic [15:0] source_address;
        logic [15:0] dest_address;
    } lpcf_cfg_t;

    typedef struct packed {
        logic        mode;
        logic [15:0] src_service;
        logic [15:0] dst_service;
        logic [7:0]  payload_length;
        logic [7:0]  ack_byte;
        logic [7:0]  sequence_number;
        logic [7:0]  payload_byte;
    } lpcf_item_t;

    typedef struct packed {
        logic [15:0] payload_crc;
        logic [7:0]  header_check;
    } lpcf_result_t;

    // sum of the two bytes of a word, mod 256
    function automatic logic [7:0] word_bytes_sum(input logic [15:0] w);
        return w[15:8] + w[7:0];
    endfunction

    // one byte of the shift-and-xor CRC
    function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] t;
        logic [15:0] n;
        t = {c[3:0], 12'h000} ^ {c[7:0], 8'h00};
        n = {b, c[15:8]};
        return n ^ t ^ (t >> 5) ^ (t >> 12);
    endfunction

endpackage

### design/lpcf_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcf_cfg_regs
// Header configuration registers: frame constant and address words.
// ----------------------------------------------------------------------------
module lpcf_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [lpcf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpcf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output lpcf_pkg::lpcf_cfg_t           cfg
);
    import lpcf_pkg::*;

    lpcf_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_constant <= FRAME_CONSTANT_RST;
            cfg_reg.source_address <= SOURCE_ADDRESS_RST;
            cfg_reg.dest_address   <= DEST_ADDRESS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FRAME_CONSTANT: cfg_reg.frame_constant <= cfg_wdata;
                CFG_SOURCE_ADDRESS: cfg_reg.source_address <= cfg_wdata;
                CFG_DEST_ADDRESS:   cfg_reg.dest_address   <= cfg_wdata;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### design/lpcf_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcf_engine
// Packet state, running CRC and header byte sum; flags the closing item.
// ----------------------------------------------------------------------------
module lpcf_engine (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  lpcf_pkg::lpcf_item_t   item,
    input  lpcf_pkg::lpcf_cfg_t    cfg,
    output logic                   emit,
    output lpcf_pkg::lpcf_result_t result
);
    import lpcf_pkg::*;

    logic [15:0] crc_reg,    crc_next;
    logic [7:0]  left_reg,   left_next;
    logic [7:0]  hsum_reg,   hsum_next;
    logic        in_pkt_reg, in_pkt_next;

    logic [7:0]  left_dec;
    logic [7:0]  header_sum;

    assign header_sum = word_bytes_sum(cfg.frame_constant)
                      + word_bytes_sum(cfg.source_address)
                      + word_bytes_sum(item.src_service)
                      + word_bytes_sum(cfg.dest_address)
                      + word_bytes_sum(item.dst_service)
                      + item.payload_length + item.ack_byte + item.sequence_number;

    assign left_dec = left_reg - 8'd1;

    always_comb begin
        crc_next    = crc_reg;
        left_next   = left_reg;
        hsum_next   = hsum_reg;
        in_pkt_next = in_pkt_reg;
        emit        = 1'b0;
        if (item.mode == MODE_HEADER) begin
            // a header always restarts, dropping any open packet
            crc_next    = 16'h0000;
            hsum_next   = header_sum;
            left_next   = item.payload_length;
            in_pkt_next = 1'b1;
            emit        = (item.payload_length == 8'd0);
        end else if (in_pkt_reg) begin
            crc_next  = crc_update(crc_reg, item.payload_byte);
            left_next = left_dec;
            emit      = (left_dec == 8'd0);
        end
        if (emit) begin
            in_pkt_next = 1'b0;
            left_next   = 8'd0;
        end
    end

    assign result.payload_crc  = crc_next;
    assign result.header_check = hsum_next + word_bytes_sum(crc_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg    <= 16'h0000;
            left_reg   <= 8'd0;
            hsum_reg   <= 8'd0;
            in_pkt_reg <= 1'b0;
        end else if (step) begin
            crc_reg    <= crc_next;
            left_reg   <= left_next;
            hsum_reg   <= hsum_next;
            in_pkt_reg <= in_pkt_next;
        end
    end

endmodule

### design/link_packet_checksum_framer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_packet_checksum_framer_top
// Computes the payload CRC and header byte sum of an outgoing link packet.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one transaction per item. mode 0 is a header that
//   opens a packet; mode 1 carries one payload byte. Payload bytes past the
//   declared length, or with no open packet, are dropped silently.
//   Result channel (m_*): one transaction per closed packet, carrying the
//   16-bit payload CRC and the 8-bit sum of 13 header bytes and 2 CRC bytes.
//   Config port (cfg_*): plain write, no handshake; registers are sampled
//   when a header is processed. Write only while the block is idle.
// Pipeline:
//   Input register, combinational engine logic, result register: the
//   closing item waits in the input register, then its result loads the
//   result register, which drives m_valid. One item per cycle sustained
//   unless m_ready stalls; the CRC byte update is a single xor network.
// Reset (aresetn low, synchronous): registers return to their defaults,
//   the packet state is idle and both pipeline registers are emptied.
// Stall: while m_ready is low with a result pending, the input register
//   still accepts one item; further input backs up through s_ready.
// ----------------------------------------------------------------------------
module link_packet_checksum_framer_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [lpcf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpcf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_mode,
    input  logic [15:0]                     s_src_service,
    input  logic [15:0]                     s_dst_service,
    input  logic [7:0]                      s_payload_length,
    input  logic [7:0]                      s_ack_byte,
    input  logic [7:0]                      s_sequence_number,
    input  logic [7:0]                      s_payload_byte,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [15:0]                     m_payload_crc,
    output logic [7:0]                      m_header_check
);
    import lpcf_pkg::*;

    lpcf_cfg_t    cfg;
    lpcf_item_t   item_reg;
    logic         item_vld_reg;
    lpcf_result_t res_reg;
    logic         res_vld_reg;

    logic         step;
    logic         emit;
    lpcf_result_t result;

    // The held item moves into the engine when the result register can
    // take whatever it produces (empty, or being drained this cycle).
    assign step    = item_vld_reg && (!res_vld_reg || m_ready);
    assign s_ready = !item_vld_reg || step;

    lpcf_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_vld_reg <= 1'b0;
        end else if (s_ready) begin
            item_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.mode            <= s_mode;
            item_reg.src_service     <= s_src_service;
            item_reg.dst_service     <= s_dst_service;
            item_reg.payload_length  <= s_payload_length;
            item_reg.ack_byte        <= s_ack_byte;
            item_reg.sequence_number <= s_sequence_number;
            item_reg.payload_byte    <= s_payload_byte;
        end
    end

    lpcf_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (item_reg),
        .cfg     (cfg),
        .emit    (emit),
        .result  (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_vld_reg <= 1'b0;
        end else if (step && emit) begin
            res_vld_reg <= 1'b1;
        end else if (m_ready) begin
            res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && emit) begin
            res_reg <= result;
        end
    end

    assign m_valid        = res_vld_reg;
    assign m_payload_crc  = res_reg.payload_crc;
    assign m_header_check = res_reg.header_check;

endmodule

### bench/lpcf_check_field_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcf_check_field_checker
// Watches the input and result channels of the framer. It keeps a shadow of
// the header registers and the packet state, works out the payload CRC and
// header sum of every packet that closes, and compares each result
// transaction against the oldest outstanding pair.
// ----------------------------------------------------------------------------
module lpcf_check_field_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [lpcf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpcf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_mode,
    input  logic [15:0]                     s_src_service,
    input  logic [15:0]                     s_dst_service,
    input  logic [7:0]                      s_payload_length,
    input  logic [7:0]                      s_ack_byte,
    input  logic [7:0]                      s_sequence_number,
    input  logic [7:0]                      s_payload_byte,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [15:0]                     m_payload_crc,
    input  logic [7:0]                      m_header_check,
    output int                              mismatch_count,
    output int                              results_due
);
    import lpcf_pkg::*;

    // shadow header registers
    logic [15:0] frame_word;
    logic [15:0] src_word;
    logic [15:0] dst_word;

    // packet state
    logic [15:0] crc_acc;
    logic [7:0]  bytes_due;
    logic [7:0]  hdr_sum;
    logic        packet_open;

    lpcf_result_t check_fields_due[$];

    function automatic logic [7:0] byte_pair_sum(input logic [15:0] w);
        logic [7:0] s;
        s = w[15:8] + w[7:0];
        return s;
    endfunction

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] t;
        t = (c << 12) ^ (c << 8);
        return {b, c[15:8]} ^ t ^ (t >> 5) ^ (t >> 12);
    endfunction

    always @(posedge aclk) begin : track
        lpcf_result_t want;
        if (!aresetn) begin
            frame_word     = FRAME_CONSTANT_RST;
            src_word       = SOURCE_ADDRESS_RST;
            dst_word       = DEST_ADDRESS_RST;
            crc_acc        = '0;
            bytes_due      = '0;
            hdr_sum        = '0;
            packet_open    = 1'b0;
            mismatch_count = 0;
            check_fields_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_FRAME_CONSTANT: frame_word = cfg_wdata;
                    CFG_SOURCE_ADDRESS: src_word   = cfg_wdata;
                    CFG_DEST_ADDRESS:   dst_word   = cfg_wdata;
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                if (s_mode == MODE_HEADER) begin
                    // a header always restarts, dropping any open packet
                    hdr_sum = byte_pair_sum(frame_word) + byte_pair_sum(src_word)
                            + byte_pair_sum(s_src_service) + byte_pair_sum(dst_word)
                            + byte_pair_sum(s_dst_service) + s_payload_length
                            + s_ack_byte + s_sequence_number;
                    crc_acc     = '0;
                    bytes_due   = s_payload_length;
                    packet_open = 1'b1;
                    if (s_payload_length == 8'd0) begin
                        check_fields_due.push_back('{payload_crc: 16'h0000,
                                                     header_check: hdr_sum});
                        packet_open = 1'b0;
                    end
                end else if (packet_open) begin
                    crc_acc   = crc_step(crc_acc, s_payload_byte);
                    bytes_due = bytes_due - 8'd1;
                    if (bytes_due == 8'd0) begin
                        check_fields_due.push_back('{payload_crc: crc_acc,
                            header_check: hdr_sum + byte_pair_sum(crc_acc)});
                        packet_open = 1'b0;
                    end
                end
            end

            if (m_valid && m_ready) begin
                if (check_fields_due.size() == 0) begin
                    $error("unexpected result: payload_crc %h header_check %h",
                           m_payload_crc, m_header_check);
                    mismatch_count++;
                end else begin
                    want = check_fields_due.pop_front();
                    if (m_payload_crc !== want.payload_crc) begin
                        $error("payload_crc mismatch: expected %h, actual %h",
                               want.payload_crc, m_payload_crc);
                        mismatch_count++;
                    end
                    if (m_header_check !== want.header_check) begin
                        $error("header_check mismatch: expected %h, actual %h",
                               want.header_check, m_header_check);
                        mismatch_count++;
                    end
                end
            end
        end
        results_due = check_fields_due.size();
    end

endmodule

### bench/link_packet_checksum_framer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_packet_checksum_framer_top_tb
// Drives header and payload transactions into the framer under several
// register settings and backpressure mixes; a checker instance beside the
// block predicts each result and counts mismatches for the final verdict.
// ----------------------------------------------------------------------------
module link_packet_checksum_framer_top_tb;
    import lpcf_pkg::*;

    localparam int DRAIN_LIMIT     = 20000; // cycles allowed for results to drain
    localparam int SETTLE_CYCLES   = 8;     // covers the input and result registers
    localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_mode;
    logic [15:0]           s_src_service;
    logic [15:0]           s_dst_service;
    logic [7:0]            s_payload_length;
    logic [7:0]            s_ack_byte;
    logic [7:0]            s_sequence_number;
    logic [7:0]            s_payload_byte;
    logic                  m_valid;
    logic                  m_ready;
    logic [15:0]           m_payload_crc;
    logic [7:0]            m_header_check;

    int mismatch_count;
    int results_due;

    // idle mix, percent of cycles; changed per phase
    int gap_pct;
    int stall_pct;
    bit hold_request;   // asks the result sink for one long stall
    bit drain_stuck;    // results never drained

    link_packet_checksum_framer_top dut (.*);

    lpcf_check_field_checker check_fields (.*);

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Result sink: random stalls at stall_pct, plus one long hold-off on
    // request. The hold-off is counted here so the sender keeps pushing
    // until the block backs up through s_ready.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Header with random fields; payload_byte is junk and must be ignored.
    function automatic lpcf_item_t header_item(input logic [7:0] len);
        lpcf_item_t it;
        it.mode            = MODE_HEADER;
        it.src_service     = 16'($urandom);
        it.dst_service     = 16'($urandom);
        it.payload_length  = len;
        it.ack_byte        = 8'($urandom);
        it.sequence_number = 8'($urandom);
        it.payload_byte    = 8'($urandom);
        return it;
    endfunction

    // Payload byte; the header fields carry junk that must be ignored.
    function automatic lpcf_item_t byte_item(input logic [7:0] b);
        lpcf_item_t it;
        it              = header_item(8'($urandom));
        it.mode         = MODE_PAYLOAD;
        it.payload_byte = b;
        return it;
    endfunction

    // One input transaction. Entered and left at a falling edge; valid is
    // only dropped during a sender gap, never between back-to-back items.
    task automatic send_item(input lpcf_item_t it);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_mode            <= it.mode;
        s_src_service     <= it.src_service;
        s_dst_service     <= it.dst_service;
        s_payload_length  <= it.payload_length;
        s_ack_byte        <= it.ack_byte;
        s_sequence_number <= it.sequence_number;
        s_payload_byte    <= it.payload_byte;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_packet(input int len);
        send_item(header_item(8'(len)));
        repeat (len) send_item(byte_item(8'($urandom)));
    endtask

    // Write all three header registers on consecutive cycles.
    task automatic load_regs(input logic [15:0] fc, input logic [15:0] sa,
                             input logic [15:0] da);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_FRAME_CONSTANT;
        cfg_wdata <= fc;
        @(negedge aclk);
        cfg_index <= CFG_SOURCE_ADDRESS;
        cfg_wdata <= sa;
        @(negedge aclk);
        cfg_index <= CFG_DEST_ADDRESS;
        cfg_wdata <= da;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Stop sending, wait for every predicted result, then let any trailing
    // item that produces no result clear the pipeline.
    task automatic settle();
        int waited;
        waited  = 0;
        s_valid <= 1'b0;
        while (results_due != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        if (results_due != 0)
            drain_stuck = 1'b1;
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Mostly well-formed short packets, some truncated packets that the
    // next header drops, and some stray bytes sent with no packet open.
    // Only items the block acts on count toward the target.
    task automatic run_traffic(input int target);
        int sent;
        int len;
        int cut;
        int pick;
        bit open;
        sent = 0;
        open = 1'b0;
        while (sent < target) begin
            pick = $urandom_range(99);
            if (pick < 10 && !open) begin
                repeat ($urandom_range(1, 3)) send_item(byte_item(8'($urandom)));
            end else if (pick < 20) begin
                len = $urandom_range(1, 255);
                cut = $urandom_range(0, (len < 4) ? len - 1 : 3);
                send_item(header_item(8'(len)));
                repeat (cut) send_item(byte_item(8'($urandom)));
                sent += 1 + cut;
                open = 1'b1;
            end else begin
                len = $urandom_range(0, 8);
                send_packet(len);
                sent += 1 + len;
                open = 1'b0;
            end
        end
        // close a dangling packet so the block ends idle
        if (open)
            send_packet(0);
    endtask

    initial begin : stimulus
        lpcf_item_t it;

        aresetn           = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = CFG_FRAME_CONSTANT;
        cfg_wdata         = '0;
        s_valid           = 1'b0;
        s_mode            = MODE_HEADER;
        s_src_service     = '0;
        s_dst_service     = '0;
        s_payload_length  = '0;
        s_ack_byte        = '0;
        s_sequence_number = '0;
        s_payload_byte    = '0;
        gap_pct           = 0;
        stall_pct         = 0;
        hold_request      = 1'b0;
        drain_stuck       = 1'b0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed cases at reset register values, no idling.
        // zero-length headers with all-zero and all-one fields
        it                 = header_item(8'd0);
        it.src_service     = 16'h0000;
        it.dst_service     = 16'h0000;
        it.ack_byte        = 8'h00;
        it.sequence_number = 8'h00;
        send_item(it);
        it.src_service     = 16'hFFFF;
        it.dst_service     = 16'hFFFF;
        it.ack_byte        = 8'hFF;
        it.sequence_number = 8'hFF;
        send_item(it);
        // stray byte with no packet open
        send_item(byte_item(8'hC3));
        // extreme payload bytes, then one past the declared length
        send_item(header_item(8'd2));
        send_item(byte_item(8'h00));
        send_item(byte_item(8'hFF));
        send_item(byte_item(8'hA5));
        // packet cut short by a new header
        send_item(header_item(8'd3));
        send_item(byte_item(8'h11));
        send_item(header_item(8'd1));
        send_item(byte_item(8'h5A));
        settle();

        // Phase: no idling, one maximum-length packet then mixed traffic.
        send_packet(255);
        run_traffic(30);
        settle();

        // Phase: all-zero registers, sender gaps.
        load_regs(16'h0000, 16'h0000, 16'h0000);
        gap_pct   = 53;
        stall_pct = 0;
        run_traffic(30);
        settle();

        // Phase: all-one registers, receiver stalls.
        load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
        gap_pct   = 0;
        stall_pct = 53;
        run_traffic(30);
        settle();

        // Phase: random registers, both sides idle.
        load_regs(16'($urandom), 16'($urandom), 16'($urandom));
        gap_pct   = 38;
        stall_pct = 38;
        run_traffic(30);
        settle();

        // Phase: long receiver hold-off while the sender streams, so the
        // result register and input register fill and s_ready drops.
        load_regs(16'hFFFF, 16'h0000, 16'($urandom));
        gap_pct      = 0;
        stall_pct    = 0;
        hold_request = 1'b1;
        run_traffic(30);
        settle();

        if (mismatch_count == 0 && !drain_stuck)
            $display("link_packet_checksum_framer_top_tb passed");
        else
            $display("link_packet_checksum_framer_top_tb failed");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #(5_000_000);
        $display("link_packet_checksum_framer_top_tb failed");
        $finish;
    end

endmodule

### sim.f
design/lpcf_pkg.sv
design/lpcf_cfg_regs.sv
design/lpcf_engine.sv
design/link_packet_checksum_framer_top.sv
bench/lpcf_check_field_checker.sv
bench/link_packet_checksum_framer_top_tb.sv
